>>> hdl/prfd_pkg.sv
package prfd_pkg;

  // Field and register widths
  localparam int TIME_W     = 16;
  localparam int RATIO_W    = 8;
  localparam int IDLE_W     = 8;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 8;

  // Default frame length in bits
  localparam int FRAME_BITS_DEF = 48;

  // Register reset values
  localparam logic [RATIO_W-1:0] PREAMBLE_RST = 8'd20;
  localparam logic [RATIO_W-1:0] ZERO_RST     = 8'd2;
  localparam logic [RATIO_W-1:0] ONE_RST      = 8'd2;
  localparam logic [IDLE_W-1:0]  QUIET_RST    = 8'd10;

  // Idle counter saturates here
  localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

  // Register indexes on the config port
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PREAMBLE = 2'd0,
    REG_ZERO     = 2'd1,
    REG_ONE      = 2'd2,
    REG_QUIET    = 2'd3
  } cfg_reg_t;

  // Input item kind
  typedef enum logic {
    CMD_SYMBOL = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_t;

  // Result flags, frame_ready in bit 0
  typedef struct packed {
    logic air_clean;
    logic frame_error;
    logic frame_ready;
  } prfd_flags_t;

  // a > b and a >= k*b, without any division
  function automatic logic ratio_at_least(input logic [TIME_W-1:0]  a,
                                          input logic [TIME_W-1:0]  b,
                                          input logic [RATIO_W-1:0] k);
    logic [TIME_W+RATIO_W-1:0] kb;
    kb = k * b;
    return (a > b) && ({{RATIO_W{1'b0}}, a} >= kb);
  endfunction

endpackage

>>> hdl/prfd_core.sv
module prfd_core #(
  parameter int FRAME_BITS = prfd_pkg::FRAME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [prfd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [prfd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                step_en,
  input  prfd_pkg::cmd_t                      cmd,
  input  logic [prfd_pkg::TIME_W-1:0]         high_time,
  input  logic [prfd_pkg::TIME_W-1:0]         low_time,
  output logic [FRAME_BITS-1:0]               frame_bits,
  output prfd_pkg::prfd_flags_t               flags
);
  import prfd_pkg::*;

  localparam int CNT_W = $clog2(FRAME_BITS);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(FRAME_BITS - 1);

  // Config registers
  logic [RATIO_W-1:0] preamble_ratio;
  logic [RATIO_W-1:0] zero_ratio;
  logic [RATIO_W-1:0] one_ratio;
  logic [IDLE_W-1:0]  quiet_ticks;

  // Decoder state
  logic                  in_frame, in_frame_next;
  logic [CNT_W-1:0]      bit_count, bit_count_next;
  logic [FRAME_BITS-1:0] shift_bits, shift_bits_next;
  logic [IDLE_W-1:0]     idle_ticks, idle_ticks_next;

  logic                  is_preamble, is_zero, is_one;
  logic [FRAME_BITS-1:0] shifted;

  // Ratio tests, one multiply each
  assign is_preamble = ratio_at_least(low_time, high_time, preamble_ratio);
  assign is_zero     = ratio_at_least(low_time, high_time, zero_ratio);
  assign is_one      = ratio_at_least(high_time, low_time, one_ratio);
  // zero wins when both pass
  assign shifted     = {shift_bits[FRAME_BITS-2:0], ~is_zero};

  // One step of the decoder
  always_comb begin
    in_frame_next   = in_frame;
    bit_count_next  = bit_count;
    shift_bits_next = shift_bits;
    idle_ticks_next = idle_ticks;
    frame_bits      = '0;
    flags           = '0;

    if (cmd == CMD_TICK) begin
      if (idle_ticks < IDLE_MAX) begin
        idle_ticks_next = idle_ticks + 1'b1;
      end
    end else if (!in_frame) begin
      // waiting: only a preamble matters, idle count untouched
      if (is_preamble) begin
        in_frame_next   = 1'b1;
        bit_count_next  = '0;
        shift_bits_next = '0;
      end
    end else begin
      idle_ticks_next = '0;
      if (is_zero || is_one) begin
        if (bit_count == LAST_BIT) begin
          flags.frame_ready = 1'b1;
          frame_bits        = shifted;
          in_frame_next     = 1'b0;
          bit_count_next    = '0;
          shift_bits_next   = '0;
        end else begin
          shift_bits_next = shifted;
          bit_count_next  = bit_count + 1'b1;
        end
      end else begin
        // unrecognized symbol aborts the frame
        flags.frame_error = 1'b1;
        in_frame_next     = 1'b0;
        bit_count_next    = '0;
        shift_bits_next   = '0;
      end
    end

    flags.air_clean = (idle_ticks_next > quiet_ticks);
  end

  // Config and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_ratio <= PREAMBLE_RST;
      zero_ratio     <= ZERO_RST;
      one_ratio      <= ONE_RST;
      quiet_ticks    <= QUIET_RST;
      in_frame       <= 1'b0;
      bit_count      <= '0;
      shift_bits     <= '0;
      idle_ticks     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_PREAMBLE: preamble_ratio <= cfg_wdata;
          REG_ZERO:     zero_ratio     <= cfg_wdata;
          REG_ONE:      one_ratio      <= cfg_wdata;
          REG_QUIET:    quiet_ticks    <= cfg_wdata;
          default:      ;
        endcase
      end
      if (step_en) begin
        in_frame   <= in_frame_next;
        bit_count  <= bit_count_next;
        shift_bits <= shift_bits_next;
        idle_ticks <= idle_ticks_next;
      end
    end
  end

endmodule

>>> hdl/pulse_ratio_frame_decoder.sv
// Pulse-width-ratio frame decoder. Each input beat is a radio symbol (high and
// low durations) or a millisecond tick, and each one yields exactly one output
// beat: frame flags, the finished frame when one completes, and the air-clean
// status. One beat is taken every clock cycle while the output is not stalled;
// a beat passes through the input register, then one decode step of three
// 8x16 ratio compares and a shift into the result register, from which it
// leaves. Decoder state is updated in that single step, so back-to-back beats
// see each other's effect.
// Write config only while no beat is in flight.
module pulse_ratio_frame_decoder #(
  parameter int FRAME_BITS = prfd_pkg::FRAME_BITS_DEF,
  localparam int DATA_W    = ((FRAME_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // config write port
  input  logic                            cfg_we,
  input  logic [prfd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [prfd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // symbol / tick input
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [2*prfd_pkg::TIME_W-1:0]   s_axis_tdata,  // high_time, low_time
  input  logic [0:0]                      s_axis_tuser,  // cmd
  // frame result output
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [DATA_W-1:0]               m_axis_tdata,  // frame_bits, zero pad
  output logic [2:0]                      m_axis_tuser   // frame_ready, frame_error,
                                                         // air_clean
);
  import prfd_pkg::*;

  // Input register
  logic                  i_valid;
  cmd_t                  i_cmd;
  logic [TIME_W-1:0]     i_high;
  logic [TIME_W-1:0]     i_low;

  // Result register
  logic                  o_valid;
  logic [FRAME_BITS-1:0] o_bits;
  prfd_flags_t           o_flags;

  logic                  advance;
  logic [FRAME_BITS-1:0] step_bits;
  prfd_flags_t           step_flags;

  // Result slot free or draining this cycle
  assign advance       = !o_valid || m_axis_tready;
  assign s_axis_tready = !i_valid || advance;

  prfd_core #(
    .FRAME_BITS (FRAME_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .step_en    (i_valid && advance),
    .cmd        (i_cmd),
    .high_time  (i_high),
    .low_time   (i_low),
    .frame_bits (step_bits),
    .flags      (step_flags)
  );

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      i_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        i_valid <= s_axis_tvalid;
      end
      if (advance) begin
        o_valid <= i_valid;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      i_cmd  <= cmd_t'(s_axis_tuser[0]);
      i_high <= s_axis_tdata[TIME_W-1:0];
      i_low  <= s_axis_tdata[2*TIME_W-1:TIME_W];
    end
    if (i_valid && advance) begin
      o_bits  <= step_bits;
      o_flags <= step_flags;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = DATA_W'(o_bits);
  assign m_axis_tuser  = o_flags;

endmodule

>>> hdl/prfd_checker.sv
module prfd_checker #(
  parameter int FRAME_BITS = prfd_pkg::FRAME_BITS_DEF,
  localparam int DATA_W    = ((FRAME_BITS + 7) / 8) * 8
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [DATA_W-1:0]               m_axis_tdata,
  input logic [2:0]                      m_axis_tuser
);
  import prfd_pkg::*;

  prfd_flags_t flags;
  assign flags = m_axis_tuser;

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output beat valid right after reset");

  // A stalled beat holds its frame
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed");

  // A draining output never blocks the input side
  a_flow: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

  // Frame data only with a completed frame, never with an error
  a_frame: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !flags.frame_ready |-> m_axis_tdata == '0)
    else $error("frame bits without frame_ready");

  // Any symbol inside a frame clears the idle count, so no air-clean with it
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (flags.frame_ready || flags.frame_error)
      |-> !flags.air_clean && !(flags.frame_ready && flags.frame_error))
    else $error("inconsistent result flags");

endmodule

bind pulse_ratio_frame_decoder prfd_checker #(
  .FRAME_BITS (FRAME_BITS)
) u_prfd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
